>>> design/dwo_pkg.sv
package dwo_pkg;

  localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int CORDIC_STEPS = 30;
  localparam logic [15:0] RADIUS_RST = 16'd2163;
  localparam logic [17:0] SEP_RST = 18'd19464;
  localparam logic [19:0] US_PER_S = 20'd1000000;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_SEP    = 2'd1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_DQ_GO,
    OP_DQ_TAKE,
    OP_STEP,
    OP_HEAD,
    OP_C1_GO,
    OP_C1_TAKE,
    OP_PMUL,
    OP_PADD,
    OP_C2_GO,
    OP_C2_TAKE,
    OP_LIN_GO,
    OP_LIN_TAKE,
    OP_ANG_GO,
    OP_ANG_TAKE,
    OP_AMUL,
    OP_AFIN,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cor_done;
    logic dt_zero;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7fff_ffff;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/diff_drive_wheel_odometry_unit.sv
// From an input transfer to out_valid, each item makes three 64-step passes of the
// shared radix-2 divider (one when the elapsed time is zero) and two 30-step passes
// of the iterative CORDIC unit, and the result may then wait before it is output.
// The next input is taken only once the previous item is finished, and may be
// taken while a result waits.
// Reset (rst_n low, synchronous): pose, heading and stored samples clear to zero,
// wheel radius and separation return to their defaults.
module diff_drive_wheel_odometry_unit import dwo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_left_wheel_angle,
  input  logic signed [31:0] in_right_wheel_angle,
  input  logic [31:0]        in_timestamp_us,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [31:0]        out_heading,
  output logic signed [31:0] out_quat_z,
  output logic signed [31:0] out_quat_w,
  output logic signed [31:0] out_linear_velocity,
  output logic signed [31:0] out_angular_velocity,
  output logic               out_zero_interval
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dwo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  dwo_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_left_wheel_angle  (in_left_wheel_angle),
    .in_right_wheel_angle (in_right_wheel_angle),
    .in_timestamp_us      (in_timestamp_us),
    .out_pos_x            (out_pos_x),
    .out_pos_y            (out_pos_y),
    .out_heading          (out_heading),
    .out_quat_z           (out_quat_z),
    .out_quat_w           (out_quat_w),
    .out_linear_velocity  (out_linear_velocity),
    .out_angular_velocity (out_angular_velocity),
    .out_zero_interval    (out_zero_interval)
  );

endmodule

>>> design/dwo_div.sv
module dwo_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [63:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] div_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        fits;

  assign rem_sh  = {rem_r, quo_r[63]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign fits    = rem_sh >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[62:0], fits};
      rem_r <= fits ? rem_sub[31:0] : rem_sh[31:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> design/dwo_cordic.sv
module dwo_cordic import dwo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        phase,
  output logic               done,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);

  localparam logic signed [33:0] UNIT = 34'sd1073741824;

  logic signed [33:0] x_r, y_r, z_r;
  logic [4:0]         i_r;
  logic               flip_r;
  logic               busy_r;
  logic               done_r;
  logic               flip_in;
  logic [31:0]        ph_in;
  logic signed [33:0] xs, ys, at;
  logic signed [33:0] xc, yc;

  assign flip_in = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
  assign ph_in   = flip_in ? phase - 32'h8000_0000 : phase;
  assign xs      = x_r >>> i_r;
  assign ys      = y_r >>> i_r;
  assign at      = $signed({2'b00, atan_lut(i_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      i_r    <= '0;
    end else if (busy_r) begin
      i_r <= i_r + 5'd1;
      if (i_r == 5'(CORDIC_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= $signed({{2{ph_in[31]}}, ph_in});
      flip_r <= flip_in;
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  always_comb begin
    xc = (x_r > UNIT) ? UNIT : ((x_r < -UNIT) ? -UNIT : x_r);
    yc = (y_r > UNIT) ? UNIT : ((y_r < -UNIT) ? -UNIT : y_r);
    if (flip_r) begin
      xc = -xc;
      yc = -yc;
    end
  end

  assign done    = done_r;
  assign cos_q30 = xc[31:0];
  assign sin_q30 = yc[31:0];

endmodule

>>> design/dwo_dp.sv
module dwo_dp import dwo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_wdata,
  input  logic signed [31:0] in_left_wheel_angle,
  input  logic signed [31:0] in_right_wheel_angle,
  input  logic [31:0]        in_timestamp_us,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [31:0]        out_heading,
  output logic signed [31:0] out_quat_z,
  output logic signed [31:0] out_quat_w,
  output logic signed [31:0] out_linear_velocity,
  output logic signed [31:0] out_angular_velocity,
  output logic               out_zero_interval
);

  logic [15:0]        rad_r;
  logic [17:0]        sep_r;
  logic [31:0]        last_l_r, last_r_r, last_t_r;
  logic signed [31:0] x_acc_r, y_acc_r;
  logic [31:0]        head_r;

  logic signed [32:0] sum_r, diff_r;
  logic [31:0]        dt_r;
  logic               zero_r;
  logic signed [32:0] ds_r;
  logic signed [49:0] num_r;
  logic               neg_r;
  logic signed [53:0] lin_num_r;
  logic [63:0]        q_r;
  logic [31:0]        hi_r, lo_r;
  logic signed [31:0] c_r, s_r;
  logic signed [64:0] px_r, py_r;
  logic signed [31:0] lin_r, ang_r, qz_r, qw_r;
  logic [63:0]        a_r;
  logic               a_big_r;
  logic [48:0]        m_r;

  logic [31:0]        dl_u, dr_u, dt_u;
  logic signed [49:0] ds_prod, num_prod;
  logic [49:0]        num_mag;
  logic [53:0]        lin_mag;
  logic [17:0]        sep_eff;
  logic [62:0]        hi_prod, lo_prod;
  logic [31:0]        step, step_s;
  logic signed [35:0] x_sum, y_sum;
  logic signed [55:0] lin_s;
  logic signed [50:0] ang_s;
  logic [62:0]        m_prod;

  logic               div_start, div_done;
  logic [63:0]        div_dividend, div_quotient;
  logic [31:0]        div_divisor;
  logic               cor_start, cor_done;
  logic [31:0]        cor_phase;
  logic signed [31:0] cor_cos, cor_sin;

  assign dl_u     = in_left_wheel_angle - last_l_r;
  assign dr_u     = in_right_wheel_angle - last_r_r;
  assign dt_u     = in_timestamp_us - last_t_r;
  assign ds_prod  = sum_r * $signed({1'b0, rad_r});
  assign num_prod = diff_r * $signed({1'b0, rad_r});
  assign num_mag  = num_r[49] ? 50'(-num_r) : 50'(num_r);
  assign lin_mag  = lin_num_r[53] ? 54'(-lin_num_r) : 54'(lin_num_r);
  assign sep_eff  = (sep_r == '0) ? 18'd1 : sep_r;
  assign hi_prod  = 63'(q_r[63:32]) * 63'(INV_PI_Q32);
  assign lo_prod  = 63'(q_r[31:0]) * 63'(INV_PI_Q32);
  assign step     = hi_r + lo_r;
  assign step_s   = neg_r ? 32'(-step) : step;
  assign x_sum    = 36'(x_acc_r) + 36'(px_r >>> 30);
  assign y_sum    = 36'(y_acc_r) + 36'(py_r >>> 30);
  assign lin_s    = lin_num_r[53] ? -$signed({2'b00, div_quotient[53:0]})
                                  : $signed({2'b00, div_quotient[53:0]});
  assign ang_s    = neg_r ? -$signed({2'b00, m_r}) : $signed({2'b00, m_r});
  assign m_prod   = 63'(a_r[42:0]) * 63'(US_PER_S);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = q_r;
    div_divisor  = dt_r;
    cor_start    = 1'b0;
    cor_phase    = head_r;
    unique case (cmd.op)
      OP_DQ_GO: begin
        div_start    = 1'b1;
        div_dividend = {num_mag, 14'b0};
        div_divisor  = {14'b0, sep_eff};
      end
      OP_LIN_GO: begin
        div_start    = 1'b1;
        div_dividend = {10'b0, lin_mag};
      end
      OP_ANG_GO: begin
        div_start = 1'b1;
      end
      OP_C1_GO: begin
        cor_start = 1'b1;
        cor_phase = {head_r[30:0], 1'b0};
      end
      OP_C2_GO: begin
        cor_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r    <= RADIUS_RST;
      sep_r    <= SEP_RST;
      last_l_r <= '0;
      last_r_r <= '0;
      last_t_r <= '0;
      x_acc_r  <= '0;
      y_acc_r  <= '0;
      head_r   <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_RADIUS) begin
        rad_r <= cfg_wdata[15:0];
      end
      if (cfg_we && cfg_index == CFG_SEP) begin
        sep_r <= cfg_wdata;
      end
      unique case (cmd.op)
        OP_LOAD: begin
          last_l_r <= in_left_wheel_angle;
          last_r_r <= in_right_wheel_angle;
          last_t_r <= in_timestamp_us;
        end
        OP_HEAD: begin
          head_r <= head_r + step_s;
        end
        OP_PADD: begin
          x_acc_r <= sat32(64'(x_sum));
          y_acc_r <= sat32(64'(y_sum));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        sum_r  <= $signed({dr_u[31], dr_u}) + $signed({dl_u[31], dl_u});
        diff_r <= $signed({dr_u[31], dr_u}) - $signed({dl_u[31], dl_u});
        dt_r   <= dt_u;
        zero_r <= dt_u == '0;
        lin_r  <= '0;
        ang_r  <= '0;
      end
      OP_MUL: begin
        ds_r  <= 33'(ds_prod >>> 17);
        num_r <= num_prod;
      end
      OP_DQ_GO: begin
        neg_r     <= num_r[49];
        lin_num_r <= ds_r * $signed({1'b0, US_PER_S});
      end
      OP_DQ_TAKE: begin
        q_r <= div_quotient;
      end
      OP_STEP: begin
        hi_r <= hi_prod[31:0];
        lo_r <= lo_prod[62:32] == 31'd0 ? 32'd0 : {1'b0, lo_prod[62:32]};
      end
      OP_C1_TAKE: begin
        c_r <= cor_cos;
        s_r <= cor_sin;
      end
      OP_PMUL: begin
        px_r <= ds_r * c_r;
        py_r <= ds_r * s_r;
      end
      OP_C2_TAKE: begin
        qw_r <= cor_cos;
        qz_r <= cor_sin;
      end
      OP_LIN_TAKE: begin
        lin_r <= sat32(64'(lin_s));
      end
      OP_ANG_TAKE: begin
        a_r <= div_quotient;
      end
      OP_AMUL: begin
        a_big_r <= a_r > 64'h0000_0400_0000_0000;
        m_r     <= m_prod[62:14];
      end
      OP_AFIN: begin
        if (a_big_r) begin
          ang_r <= neg_r ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
          ang_r <= sat32(64'(ang_s));
        end
      end
      OP_OUT: begin
        out_pos_x            <= x_acc_r;
        out_pos_y            <= y_acc_r;
        out_heading          <= head_r;
        out_quat_z           <= qz_r;
        out_quat_w           <= qw_r;
        out_linear_velocity  <= lin_r;
        out_angular_velocity <= ang_r;
        out_zero_interval    <= zero_r;
      end
      default: begin
      end
    endcase
  end

  dwo_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  dwo_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .phase   (cor_phase),
    .done    (cor_done),
    .cos_q30 (cor_cos),
    .sin_q30 (cor_sin)
  );

  assign stat.div_done = div_done;
  assign stat.cor_done = cor_done;
  assign stat.dt_zero  = zero_r;

endmodule

>>> design/dwo_ctrl.sv
module dwo_ctrl import dwo_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_DQ_GO, S_DQ_WAIT, S_DQ_TAKE, S_STEP, S_HEAD,
    S_C1_GO, S_C1_WAIT, S_C1_TAKE, S_PMUL, S_PADD,
    S_C2_GO, S_C2_WAIT, S_C2_TAKE,
    S_LIN_GO, S_LIN_WAIT, S_LIN_TAKE,
    S_ANG_GO, S_ANG_WAIT, S_ANG_TAKE, S_AMUL, S_AFIN, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_DQ_GO;
      end
      S_DQ_GO: begin
        cmd.op    = OP_DQ_GO;
        state_nxt = S_DQ_WAIT;
      end
      S_DQ_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_DQ_TAKE;
        end
      end
      S_DQ_TAKE: begin
        cmd.op    = OP_DQ_TAKE;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        cmd.op    = OP_STEP;
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        cmd.op    = OP_HEAD;
        state_nxt = S_C1_GO;
      end
      S_C1_GO: begin
        cmd.op    = OP_C1_GO;
        state_nxt = S_C1_WAIT;
      end
      S_C1_WAIT: begin
        if (stat.cor_done) begin
          state_nxt = S_C1_TAKE;
        end
      end
      S_C1_TAKE: begin
        cmd.op    = OP_C1_TAKE;
        state_nxt = S_PMUL;
      end
      S_PMUL: begin
        cmd.op    = OP_PMUL;
        state_nxt = S_PADD;
      end
      S_PADD: begin
        cmd.op    = OP_PADD;
        state_nxt = S_C2_GO;
      end
      S_C2_GO: begin
        cmd.op    = OP_C2_GO;
        state_nxt = S_C2_WAIT;
      end
      S_C2_WAIT: begin
        if (stat.cor_done) begin
          state_nxt = S_C2_TAKE;
        end
      end
      S_C2_TAKE: begin
        cmd.op    = OP_C2_TAKE;
        state_nxt = stat.dt_zero ? S_OUT : S_LIN_GO;
      end
      S_LIN_GO: begin
        cmd.op    = OP_LIN_GO;
        state_nxt = S_LIN_WAIT;
      end
      S_LIN_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_LIN_TAKE;
        end
      end
      S_LIN_TAKE: begin
        cmd.op    = OP_LIN_TAKE;
        state_nxt = S_ANG_GO;
      end
      S_ANG_GO: begin
        cmd.op    = OP_ANG_GO;
        state_nxt = S_ANG_WAIT;
      end
      S_ANG_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_ANG_TAKE;
        end
      end
      S_ANG_TAKE: begin
        cmd.op    = OP_ANG_TAKE;
        state_nxt = S_AMUL;
      end
      S_AMUL: begin
        cmd.op    = OP_AMUL;
        state_nxt = S_AFIN;
      end
      S_AFIN: begin
        cmd.op    = OP_AFIN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

>>> design/dwo_chk.sv
module dwo_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_pos_x,
  input logic signed [31:0] out_pos_y,
  input logic [31:0]        out_heading,
  input logic signed [31:0] out_quat_z,
  input logic signed [31:0] out_quat_w,
  input logic signed [31:0] out_linear_velocity,
  input logic signed [31:0] out_angular_velocity,
  input logic               out_zero_interval
);

  // hold off further input while an item is in work
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pos_x) && $stable(out_pos_y)
      && $stable(out_heading) && $stable(out_linear_velocity))
    else $error("stalled result changed");

  a_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_interval |->
      out_linear_velocity == 32'sd0 && out_angular_velocity == 32'sd0)
    else $error("velocity not zero on zero interval");

  a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_quat_z <= 32'sd1073741824 && out_quat_z >= -32'sd1073741824
      && out_quat_w <= 32'sd1073741824 && out_quat_w >= -32'sd1073741824)
    else $error("quaternion component out of range");

endmodule

bind diff_drive_wheel_odometry_unit dwo_chk u_dwo_chk (.*);
